// ===== rtl/pwc_pkg.sv =====
// Shared constants and types for the particle wall and collision step unit.
// No dependencies; every other file of the block imports this package.
package pwc_pkg;

  // Packed vector field width on the ports (three components).
  localparam int PACK_W = 63;
  // Default and largest component format.
  localparam int CW_DEF = 21;
  localparam int CW_MAX = 21;
  localparam int FB_DEF = 16;
  // Time step is unsigned Q0.16.
  localparam int DT_W = 16;
  localparam int STEP_FB = 16;
  localparam int PIST_W = 20;
  localparam int MASS_W = 8;
  localparam int MSUM_W = MASS_W + 1;
  // Exchange numerators, sized for the largest component width.
  localparam int NUM_W = CW_MAX + 11;
  localparam int Q_DEPTH_DEF = 4;

  typedef enum logic {
    KIND_MOTION  = 1'b0,
    KIND_COLLIDE = 1'b1
  } kind_t;

  // One classified item as it waits between the front and the back part.
  typedef struct packed {
    kind_t                       kind;
    logic                        exch;
    logic [2:0]                  hits;
    logic [MSUM_W-1:0]           msum;
    logic [PACK_W-1:0]           pos;
    logic [PACK_W-1:0]           va;
    logic [PACK_W-1:0]           vb;
    logic [2:0][NUM_W-1:0]       num_a;
    logic [2:0][NUM_W-1:0]       num_b;
  } qent_t;

endpackage

// ===== rtl/pwc_ifs.sv =====
// Valid/ready channel interfaces for the particle step unit.
// Depends on pwc_pkg for the field widths.
interface pwc_in_if;
  import pwc_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PACK_W-1:0] pos_a;
  logic [PACK_W-1:0] vel_a;
  logic [MASS_W-1:0] mass_a;
  logic [PACK_W-1:0] pos_b;
  logic [PACK_W-1:0] vel_b;
  logic [MASS_W-1:0] mass_b;
  logic [DT_W-1:0]   time_step;
  logic [PIST_W-1:0] piston_x;

  modport source(output valid, kind, pos_a, vel_a, mass_a, pos_b, vel_b, mass_b,
                 time_step, piston_x, input ready);
  modport sink(input valid, kind, pos_a, vel_a, mass_a, pos_b, vel_b, mass_b,
               time_step, piston_x, output ready);
endinterface

interface pwc_out_if;
  import pwc_pkg::*;
  logic              valid;
  logic              ready;
  logic [PACK_W-1:0] new_pos_a;
  logic [PACK_W-1:0] new_vel_a;
  logic [PACK_W-1:0] new_vel_b;
  logic [2:0]        wall_hits;
  logic              exchanged;

  modport source(output valid, new_pos_a, new_vel_a, new_vel_b, wall_hits, exchanged,
                 input ready);
  modport sink(input valid, new_pos_a, new_vel_a, new_vel_b, wall_hits, exchanged,
               output ready);
endinterface

// ===== rtl/pwc_front.sv =====
// Front part: accepts items, forms all products, finishes the motion step
// and classifies collisions. Depends on pwc_pkg and pwc_in_if.
module pwc_front #(
  parameter int COMPONENT_WIDTH = pwc_pkg::CW_DEF,
  parameter int FRACTION_BITS   = pwc_pkg::FB_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  pwc_in_if.sink          in_ch,
  output logic            q_push,
  output pwc_pkg::qent_t  q_wdata,
  input  logic            q_full
);
  import pwc_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int PW   = 3 * CW;
  localparam int DW   = CW + DT_W + 1;
  localparam int DPW  = CW + 1;
  localparam int DOTW = 2 * DPW;
  localparam int TW   = CW + 11;
  localparam int EW   = ((CW + 2) > (PIST_W + 2)) ? (CW + 2) : (PIST_W + 2);
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int ONE_LIM = ((1 << FRACTION_BITS) > CMAX) ? CMAX : (1 << FRACTION_BITS);
  localparam logic signed [EW-1:0] CMAX_E = EW'(CMAX);
  localparam logic signed [EW-1:0] ONE_E  = EW'(ONE_LIM);
  localparam logic signed [CW-1:0] CMAX_C = CW'(CMAX);
  localparam logic signed [CW-1:0] CMIN_C = ~CMAX_C;

  // Stage register holding the products of the accepted item.
  logic                    v1_r, v1_nxt;
  logic                    kind_r;
  logic [PW-1:0]           pos_a_r, vel_a_r, vel_b_r;
  logic [PIST_W-1:0]       piston_r;
  logic [MSUM_W-1:0]       msum_r;
  logic signed [DW-1:0]    disp_r   [3];
  logic signed [DOTW-1:0]  dotp_r   [3];
  logic signed [TW-1:0]    ta_r [3], tb_r [3], tc_r [3], td_r [3];

  logic signed [DW-1:0]    disp_c   [3];
  logic signed [DOTW-1:0]  dotp_c   [3];
  logic signed [TW-1:0]    ta_c [3], tb_c [3], tc_c [3], td_c [3];

  logic in_rdy;
  logic load;

  // The stage moves whenever its item can enter the queue.
  assign in_rdy       = !v1_r || !q_full;
  assign in_ch.ready  = in_rdy;
  assign load         = in_rdy && in_ch.valid;
  assign q_push       = v1_r && !q_full;

  always_comb begin
    v1_nxt = v1_r;
    if (in_rdy) begin
      v1_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  // Products of both steps, formed straight from the accepted item.
  always_comb begin
    logic signed [CW-1:0]   pa, pb, va, vb;
    logic signed [DPW-1:0]  dp, dv;
    logic signed [MSUM_W-1:0] dma, dmb;
    logic signed [10:0]     m2a, m2b;
    logic signed [DW-1:0]   dte;
    dma = $signed({1'b0, in_ch.mass_a}) - $signed({1'b0, in_ch.mass_b});
    dmb = $signed({1'b0, in_ch.mass_b}) - $signed({1'b0, in_ch.mass_a});
    m2a = $signed({2'b00, in_ch.mass_a, 1'b0});
    m2b = $signed({2'b00, in_ch.mass_b, 1'b0});
    dte = $signed(DW'({1'b0, in_ch.time_step}));
    for (int ax = 0; ax < 3; ax++) begin
      pa = $signed(in_ch.pos_a[ax*CW +: CW]);
      pb = $signed(in_ch.pos_b[ax*CW +: CW]);
      va = $signed(in_ch.vel_a[ax*CW +: CW]);
      vb = $signed(in_ch.vel_b[ax*CW +: CW]);
      disp_c[ax] = DW'(va) * dte;
      dp = DPW'(pa) - DPW'(pb);
      dv = DPW'(va) - DPW'(vb);
      dotp_c[ax] = DOTW'(dp) * DOTW'(dv);
      ta_c[ax] = TW'(va) * TW'(dma);
      tb_c[ax] = TW'(vb) * TW'(m2b);
      tc_c[ax] = TW'(vb) * TW'(dmb);
      td_c[ax] = TW'(va) * TW'(m2a);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= in_ch.kind;
      pos_a_r  <= in_ch.pos_a[PW-1:0];
      vel_a_r  <= in_ch.vel_a[PW-1:0];
      vel_b_r  <= in_ch.vel_b[PW-1:0];
      piston_r <= in_ch.piston_x;
      msum_r   <= MSUM_W'(in_ch.mass_a) + MSUM_W'(in_ch.mass_b);
      for (int ax = 0; ax < 3; ax++) begin
        disp_r[ax] <= disp_c[ax];
        dotp_r[ax] <= dotp_c[ax];
        ta_r[ax]   <= ta_c[ax];
        tb_r[ax]   <= tb_c[ax];
        tc_r[ax]   <= tc_c[ax];
        td_r[ax]   <= td_c[ax];
      end
    end
  end

  // Motion: add the floored displacement, clamp into the box, reflect.
  // Collision: sign of the dot product and the exchange numerators.
  always_comb begin
    logic signed [EW-1:0]     pist_e, hi, sum;
    logic signed [CW-1:0]     v;
    logic                     hit;
    logic signed [DOTW+1:0]   dot;
    logic [PW-1:0]            npos, nva;
    logic [2:0]               hits;
    pist_e = $signed(EW'({1'b0, piston_r}));
    npos   = '0;
    nva    = '0;
    hits   = '0;
    for (int ax = 0; ax < 3; ax++) begin
      if (ax == 0) begin
        hi = (pist_e > CMAX_E) ? CMAX_E : pist_e;
      end else begin
        hi = ONE_E;
      end
      sum = EW'($signed(pos_a_r[ax*CW +: CW])) + EW'(disp_r[ax] >>> STEP_FB);
      v   = $signed(vel_a_r[ax*CW +: CW]);
      hit = 1'b0;
      if (sum < 0) begin
        sum = '0;
        hit = 1'b1;
      end else if (sum > hi) begin
        sum = hi;
        hit = 1'b1;
      end
      if (hit) begin
        v = (v == CMIN_C) ? CMAX_C : -v;
      end
      hits[ax] = hit;
      npos[ax*CW +: CW] = sum[CW-1:0];
      nva[ax*CW +: CW]  = v;
    end

    dot = (DOTW+2)'(dotp_r[0]) + (DOTW+2)'(dotp_r[1]) + (DOTW+2)'(dotp_r[2]);

    q_wdata.kind = kind_t'(kind_r);
    q_wdata.msum = msum_r;
    q_wdata.vb   = PACK_W'(vel_b_r);
    if (kind_r == KIND_MOTION) begin
      q_wdata.exch = 1'b0;
      q_wdata.hits = hits;
      q_wdata.pos  = PACK_W'(npos);
      q_wdata.va   = PACK_W'(nva);
    end else begin
      q_wdata.exch = (dot <= 0) && (msum_r != '0);
      q_wdata.hits = '0;
      q_wdata.pos  = PACK_W'(pos_a_r);
      q_wdata.va   = PACK_W'(vel_a_r);
    end
    for (int ax = 0; ax < 3; ax++) begin
      q_wdata.num_a[ax] = NUM_W'(ta_r[ax] + tb_r[ax]);
      q_wdata.num_b[ax] = NUM_W'(tc_r[ax] + td_r[ax]);
    end
  end

endmodule

// ===== rtl/pwc_queue.sv =====
// Short item queue between the front and back parts of the step unit.
// Depends on pwc_pkg for the entry type.
module pwc_queue #(
  parameter int DEPTH = pwc_pkg::Q_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pwc_pkg::qent_t wdata,
  output logic           full,
  input  logic           pop,
  output pwc_pkg::qent_t rdata,
  output logic           empty
);
  import pwc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  qent_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pwc_back.sv =====
// Back part: pipelined restoring dividers for the six exchange quotients,
// saturation and the output register. Depends on pwc_pkg and pwc_out_if.
module pwc_back #(
  parameter int COMPONENT_WIDTH = pwc_pkg::CW_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pwc_pkg::qent_t q_rdata,
  input  logic           q_empty,
  output logic           q_pop,
  pwc_out_if.source      out_ch
);
  import pwc_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int QB   = CW + 9;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam logic signed [QB:0]   CMAX_Q = (QB+1)'(CMAX);
  localparam logic signed [QB:0]   CMIN_Q = ~CMAX_Q;

  typedef struct packed {
    logic              neg;
    logic [QB-1:0]     dq;
    logic [MSUM_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    kind_t             kind;
    logic              exch;
    logic [2:0]        hits;
    logic [MSUM_W-1:0] msum;
    logic [PACK_W-1:0] pos;
    logic [PACK_W-1:0] va;
    logic [PACK_W-1:0] vb;
    lane_t [5:0]       ln;
  } stg_t;

  // One quotient bit for every lane.
  function automatic stg_t div_step(stg_t s);
    stg_t          o;
    logic [MSUM_W:0] t;
    o = s;
    for (int i = 0; i < 6; i++) begin
      t = {s.ln[i].rem, s.ln[i].dq[QB-1]};
      if (t >= {1'b0, s.msum}) begin
        o.ln[i].rem = MSUM_W'(t - {1'b0, s.msum});
        o.ln[i].dq  = {s.ln[i].dq[QB-2:0], 1'b1};
      end else begin
        o.ln[i].rem = t[MSUM_W-1:0];
        o.ln[i].dq  = {s.ln[i].dq[QB-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Signed quotient saturated to the component range.
  function automatic logic [CW-1:0] sat_q(lane_t l);
    logic signed [QB:0] sv;
    sv = l.neg ? -$signed({1'b0, l.dq}) : $signed({1'b0, l.dq});
    if (sv > CMAX_Q) begin
      sv = CMAX_Q;
    end else if (sv < CMIN_Q) begin
      sv = CMIN_Q;
    end
    return sv[CW-1:0];
  endfunction

  stg_t          s0_in;
  stg_t          pipe_r [QB];
  logic [QB-1:0] vld_r;
  logic          en;

  logic              out_vld_r;
  logic              out_kind_r;
  logic [PACK_W-1:0] out_pos_r, out_va_r, out_vb_r;
  logic [2:0]        out_hits_r;
  logic              out_exch_r;

  // The whole back pipeline advances unless a result waits at the output.
  assign en    = !out_vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  // Split the numerators into sign and magnitude.
  always_comb begin
    logic [NUM_W-1:0] mag;
    s0_in.kind = q_rdata.kind;
    s0_in.exch = q_rdata.exch;
    s0_in.hits = q_rdata.hits;
    s0_in.msum = q_rdata.msum;
    s0_in.pos  = q_rdata.pos;
    s0_in.va   = q_rdata.va;
    s0_in.vb   = q_rdata.vb;
    for (int i = 0; i < 6; i++) begin
      if (i < 3) begin
        mag = q_rdata.num_a[i];
      end else begin
        mag = q_rdata.num_b[i-3];
      end
      s0_in.ln[i].neg = mag[NUM_W-1];
      if (mag[NUM_W-1]) begin
        mag = -mag;
      end
      s0_in.ln[i].dq  = mag[QB-1:0];
      s0_in.ln[i].rem = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], !q_empty};
    end
  end

  // Divider stages.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[0] <= div_step(s0_in);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[k] <= div_step(pipe_r[k-1]);
        end
      end
    end
  end

  // Output register with the exchanged velocities merged in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [PACK_W-1:0] nva, nvb;
    nva = pipe_r[QB-1].va;
    nvb = pipe_r[QB-1].vb;
    if (pipe_r[QB-1].exch) begin
      for (int ax = 0; ax < 3; ax++) begin
        nva[ax*CW +: CW] = sat_q(pipe_r[QB-1].ln[ax]);
        nvb[ax*CW +: CW] = sat_q(pipe_r[QB-1].ln[ax+3]);
      end
    end
    if (en && vld_r[QB-1]) begin
      out_kind_r <= pipe_r[QB-1].kind;
      out_pos_r  <= pipe_r[QB-1].pos;
      out_va_r   <= nva;
      out_vb_r   <= nvb;
      out_hits_r <= pipe_r[QB-1].hits;
      out_exch_r <= pipe_r[QB-1].exch;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.new_pos_a = out_pos_r;
  assign out_ch.new_vel_a = out_va_r;
  assign out_ch.new_vel_b = out_vb_r;
  assign out_ch.wall_hits = out_hits_r;
  assign out_ch.exchanged = out_exch_r;

  // A popped item enters the first divider stage.
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> vld_r[0]) else $error("popped item lost before divider");

  // The pipeline only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> out_vld_r) else $error("pipeline stalled without a waiting result");

  // A stalled pipeline keeps its occupancy.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("pipeline moved while stalled");

  // Wall hits and exchange never come together, and exchange needs a collision.
  a_exch_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_exch_r |-> (out_hits_r == 3'b000) && (out_kind_r == KIND_COLLIDE))
    else $error("exchange flagged on a motion result");

endmodule

// ===== rtl/particle_wall_and_collision_step_unit.sv =====
// Particle wall and collision step unit: takes one item per clock on in_ch while
// ready is high and returns one result per item on out_ch, in order. A motion
// item advances particle A, clamps it into its box and reflects clamped axes; a
// collision item applies the mass-weighted elastic exchange when the particles
// approach. The unit sustains one item per cycle unless out_ch stalls; the
// exchange quotients come from a one-bit-per-stage divider pipeline. A short
// queue separates the accepting front part from the divider back part.
// Depends on pwc_pkg, pwc_ifs, pwc_front, pwc_queue and pwc_back.
module particle_wall_and_collision_step_unit #(
  parameter int COMPONENT_WIDTH = pwc_pkg::CW_DEF,
  parameter int FRACTION_BITS   = pwc_pkg::FB_DEF,
  parameter int QUEUE_DEPTH     = pwc_pkg::Q_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pwc_in_if.sink     in_ch,
  pwc_out_if.source  out_ch
);
  import pwc_pkg::*;

  qent_t q_wdata, q_rdata;
  logic  q_push, q_full, q_pop, q_empty;

  // Accept and classify.
  pwc_front #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_wdata(q_wdata),
    .q_full (q_full)
  );

  // Decoupling queue.
  pwc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  // Divide, saturate and deliver.
  pwc_back #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rdata(q_rdata),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/particle_wall_and_collision_step_unit_tb.sv =====
// Testbench for the particle wall and collision step unit.
// Directed and random motion and collision items go through a predictor and an
// in-order scoreboard. Depends on pwc_pkg, pwc_ifs and the unit itself.
`timescale 1ns / 100ps

module particle_wall_and_collision_step_unit_tb;
  import pwc_pkg::*;

  localparam int CW = 21;
  localparam int FB = 16;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [PACK_W-1:0] new_pos_a;
    logic [PACK_W-1:0] new_vel_a;
    logic [PACK_W-1:0] new_vel_b;
    logic [2:0]        wall_hits;
    logic              exchanged;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  pwc_in_if  in_ch();
  pwc_out_if out_ch();

  step_result_t expected_results[$];
  int  mismatches = 0;
  bit  stall_long = 1'b0;
  bit  stall_none = 1'b0;
  bit  gaps_on = 1'b1;
  longint cycles = 0;

  particle_wall_and_collision_step_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Signed component extraction and clamping to the component range.
  function automatic longint comp_of(logic [PACK_W-1:0] pv, int ax);
    logic [CW-1:0] c;
    c = pv[ax*CW +: CW];
    return longint'(signed'(c));
  endfunction

  function automatic longint clip(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // Predicts the result of one item.
  function automatic step_result_t predict_step(kind_t kind, logic [PACK_W-1:0] pa,
      logic [PACK_W-1:0] va, logic [7:0] ma, logic [PACK_W-1:0] pb,
      logic [PACK_W-1:0] vb, logic [7:0] mb, logic [15:0] dt, logic [19:0] pist);
    step_result_t r;
    longint p, v, hi, upper_x, one, dot, msum, a, b, na, nb;
    logic [CW-1:0] cp, cv, cb;
    bit hit;
    r = '0;
    if (kind == KIND_MOTION) begin
      one = 64'sd1 <<< FB;
      if (one > CMAX) one = CMAX;
      upper_x = longint'(pist);
      if (upper_x > CMAX) upper_x = CMAX;
      for (int ax = 0; ax < 3; ax++) begin
        p = comp_of(pa, ax);
        v = comp_of(va, ax);
        hi = (ax == 0) ? upper_x : one;
        p = p + ((v * longint'(dt)) >>> STEP_FB);
        hit = 1'b0;
        if (p < 0) begin
          p = 0;
          hit = 1'b1;
        end else if (p > hi) begin
          p = hi;
          hit = 1'b1;
        end
        if (hit) begin
          v = clip(-v);
          r.wall_hits[ax] = 1'b1;
        end
        cp = p[CW-1:0];
        cv = v[CW-1:0];
        r.new_pos_a[ax*CW +: CW] = cp;
        r.new_vel_a[ax*CW +: CW] = cv;
      end
      r.new_vel_b = vb;
    end else begin
      dot = 0;
      msum = longint'(ma) + longint'(mb);
      for (int ax = 0; ax < 3; ax++)
        dot += (comp_of(pa, ax) - comp_of(pb, ax)) * (comp_of(va, ax) - comp_of(vb, ax));
      r.new_pos_a = pa;
      r.exchanged = (dot <= 0) && (msum != 0);
      for (int ax = 0; ax < 3; ax++) begin
        a = comp_of(va, ax);
        b = comp_of(vb, ax);
        if (r.exchanged) begin
          na = (a * (longint'(ma) - longint'(mb)) + b * (2 * longint'(mb))) / msum;
          nb = (b * (longint'(mb) - longint'(ma)) + a * (2 * longint'(ma))) / msum;
          a = clip(na);
          b = clip(nb);
        end
        cv = a[CW-1:0];
        cb = b[CW-1:0];
        r.new_vel_a[ax*CW +: CW] = cv;
        r.new_vel_b[ax*CW +: CW] = cb;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Sends one item, records its prediction when accepted. Valid drops only
  // for an idle gap before the next item.
  task automatic send_item(kind_t kind, logic [PACK_W-1:0] pa, logic [PACK_W-1:0] va,
      logic [7:0] ma, logic [PACK_W-1:0] pb, logic [PACK_W-1:0] vb, logic [7:0] mb,
      logic [15:0] dt, logic [19:0] pist);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.pos_a     <= pa;
    in_ch.vel_a     <= va;
    in_ch.mass_a    <= ma;
    in_ch.pos_b     <= pb;
    in_ch.vel_b     <= vb;
    in_ch.mass_b    <= mb;
    in_ch.time_step <= dt;
    in_ch.piston_x  <= pist;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_step(kind, pa, va, ma, pb, vb, mb, dt, pist));
  endtask

  // Helpers build packed vectors from three components.
  function automatic logic [PACK_W-1:0] vec3(longint x, longint y, longint z);
    logic [PACK_W-1:0] v;
    v = '0;
    v[0 +: CW] = x[CW-1:0];
    v[CW +: CW] = y[CW-1:0];
    v[2*CW +: CW] = z[CW-1:0];
    return v;
  endfunction

  function automatic logic [PACK_W-1:0] rand_vec();
    return PACK_W'({$urandom(), $urandom()});
  endfunction

  // Random component mostly near the box, sometimes anywhere.
  function automatic longint rand_box_comp();
    if ($urandom_range(0, 3) == 0) return longint'(signed'(21'($urandom())));
    return longint'($urandom_range(0, 70000)) - 3000;
  endfunction

  function automatic longint rand_vel_comp();
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMAX;
      2: return longint'(signed'(21'($urandom())));
      default: return longint'($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  task automatic test_motion_directed();
    send_item(KIND_MOTION, '0, '0, 8'd1, '0, '0, 8'd1, 16'd0, 20'd0);
    send_item(KIND_MOTION, '1, '1, 8'd255, '1, '1, 8'd255, 16'hFFFF, 20'hFFFFF);
    send_item(KIND_MOTION, vec3(100, 100, 100), vec3(CMIN, CMIN, CMIN), 8'd1, '0,
              rand_vec(), 8'd1, 16'hFFFF, 20'd65536);
    send_item(KIND_MOTION, vec3(65000, 65000, 65000), vec3(CMAX, CMAX, CMAX), 8'd1, '0,
              '0, 8'd1, 16'hFFFF, 20'd65536);
    send_item(KIND_MOTION, vec3(65536, 65536, 65536), vec3(0, 0, 0), 8'd1, '0, '0, 8'd1,
              16'h8000, 20'd65536);
    send_item(KIND_MOTION, vec3(0, 0, 0), vec3(-1, -1, -1), 8'd1, '0, '0, 8'd1,
              16'd1, 20'd1000);
    send_item(KIND_MOTION, vec3(CMAX, 1, 1), vec3(5, -5, 5), 8'd1, '0, '0, 8'd1,
              16'd300, 20'hFFFFF);
    send_item(KIND_MOTION, vec3(CMIN, CMIN, CMAX), vec3(CMAX, 0, CMIN), 8'd1, '0, '0,
              8'd1, 16'hFFFF, 20'h80000);
  endtask

  task automatic test_collision_directed();
    send_item(KIND_COLLIDE, vec3(10, 10, 10), vec3(500, 0, -3), 8'd3, vec3(10, 10, 10),
              vec3(-7, 9, 1), 8'd5, '0, '0);
    send_item(KIND_COLLIDE, vec3(0, 0, 0), vec3(1000, 0, 0), 8'd1, vec3(100, 0, 0),
              vec3(-1000, 0, 0), 8'd1, '0, '0);
    send_item(KIND_COLLIDE, vec3(0, 0, 0), vec3(-1000, 0, 0), 8'd1, vec3(100, 0, 0),
              vec3(1000, 0, 0), 8'd1, '0, '0);
    send_item(KIND_COLLIDE, '0, vec3(CMAX, CMIN, CMAX), 8'd0, '0, vec3(CMIN, CMAX, 7),
              8'd0, '0, '0);
    send_item(KIND_COLLIDE, '0, vec3(CMAX, CMIN, 3), 8'd0, '0, vec3(CMIN, CMAX, 7),
              8'd255, '0, '0);
    send_item(KIND_COLLIDE, '0, vec3(CMAX, CMIN, CMAX), 8'd255, '0,
              vec3(CMIN, CMAX, CMIN), 8'd1, '0, '0);
    send_item(KIND_COLLIDE, '1, '1, 8'd255, '0, '0, 8'd255, '1, '1);
    send_item(KIND_COLLIDE, '0, '0, 8'd1, '1, '1, 8'd1, '0, '0);
  endtask

  task automatic send_random(int n);
    kind_t k;
    logic [PACK_W-1:0] pa, va, pb, vb;
    for (int i = 0; i < n; i++) begin
      k = kind_t'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        pa = rand_vec();
        va = rand_vec();
        pb = rand_vec();
        vb = rand_vec();
      end else begin
        pa = vec3(rand_box_comp(), rand_box_comp(), rand_box_comp());
        va = vec3(rand_vel_comp(), rand_vel_comp(), rand_vel_comp());
        pb = vec3(rand_box_comp(), rand_box_comp(), rand_box_comp());
        vb = vec3(rand_vel_comp(), rand_vel_comp(), rand_vel_comp());
        pa[PACK_W-1] = 1'($urandom_range(0, 1));
        vb[PACK_W-1] = 1'($urandom_range(0, 1));
      end
      send_item(k, pa, va, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                pb, vb, ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                16'($urandom()), ($urandom_range(0, 3) == 0) ? 20'($urandom())
                : 20'($urandom_range(30000, 70000)));
    end
  endtask

  task automatic test_random();
    send_random(900);
  endtask

  // Long receiver hold-off while items keep coming back to back.
  task automatic test_backpressure();
    stall_long = 1'b1;
    gaps_on = 1'b0;
    send_random(60);
    gaps_on = 1'b1;
    stall_none = 1'b1;
    send_random(40);
    stall_none = 1'b0;
  endtask

  // Receiver ready with random stalls, a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
        stall_long = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_none) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        case ($urandom_range(0, 19))
          0: out_ch.ready <= 1'b0;
          1, 2, 3: out_ch.ready <= ~out_ch.ready;
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    step_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.new_pos_a, out_ch.new_vel_a, out_ch.new_vel_b, out_ch.wall_hits,
              out_ch.exchanged};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pos %h/%h vel_a %h/%h vel_b %h/%h hits %b/%b exch %b/%b",
                     want.new_pos_a, got.new_pos_a, want.new_vel_a, got.new_vel_a,
                     want.new_vel_b, got.new_vel_b, want.wall_hits, got.wall_hits,
                     want.exchanged, got.exchanged);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("particle_wall_and_collision_step_unit_tb failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.pos_a = '0;
    in_ch.vel_a = '0;
    in_ch.mass_a = '0;
    in_ch.pos_b = '0;
    in_ch.vel_b = '0;
    in_ch.mass_b = '0;
    in_ch.time_step = '0;
    in_ch.piston_x = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_motion_directed();
    test_collision_directed();
    test_random();
    test_backpressure();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("particle_wall_and_collision_step_unit_tb passed");
    else
      $display("particle_wall_and_collision_step_unit_tb failed");
    $finish;
  end

endmodule
